### rtl/ple_pkg.sv
// Shared constants for the positional list engine.
package ple_pkg;

  localparam int CAPACITY_DEFAULT = 32;
  localparam int MAX_RESULTS = 32;
  localparam int DATA_W = 8;
  localparam int KIND_W = 2;
  localparam int POS_W = 6;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PRINT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

### rtl/positional_list_engine_core.sv
// Positional list engine: an ordered byte list held in one memory.
// Get returns one item; add at position p shifts entries p..count up one place,
// then writes the item; delete at p shifts the entries after p down, one entry a cycle.
// Print reads out up to MAX_RESULTS items, one read of the memory per item.
// Synchronous reset empties the list and drops any pending word; items are not cleared.
module positional_list_engine_core #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ple_pkg::KIND_W-1:0]    kind,
  input  logic [ple_pkg::POS_W-1:0]     position,
  input  logic [ple_pkg::DATA_W-1:0]    item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ple_pkg::STATUS_W-1:0]  status,
  output logic [ple_pkg::DATA_W-1:0]    data,
  output logic                          data_valid,
  output logic                          last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RESP = 3'd1;
  localparam logic [2:0] S_RDOUT = 3'd2;
  localparam logic [2:0] S_SHUP = 3'd3;
  localparam logic [2:0] S_SHDN = 3'd4;
  localparam logic [2:0] S_PUT = 3'd5;

  logic [2:0]                     state;
  logic [CW-1:0]                  count;
  logic [AW-1:0]                  p_idx;
  logic [ple_pkg::DATA_W-1:0]     p_item;
  logic [AW-1:0]                  rptr;
  logic [AW-1:0]                  wptr;
  logic [AW-1:0]                  limit;
  logic                           rd_active;
  logic                           wpend;
  logic                           is_print;
  logic [AW-1:0]                  pidx;
  logic [CW-1:0]                  pcount;
  logic [ple_pkg::STATUS_W-1:0]   resp_status;
  logic [ple_pkg::STATUS_W-1:0]   resp_status_next;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [ple_pkg::DATA_W-1:0]     mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [ple_pkg::DATA_W-1:0]     rdata;

  logic                           accept;
  logic                           out_free;
  logic                           out_load;
  logic [XW-1:0]                  posx;
  logic [XW-1:0]                  cntx;
  logic [XW-1:0]                  nsel;
  logic                           add_ok;
  logic                           rng_ok;
  logic                           full;
  logic [AW-1:0]                  pos_idx;
  logic                           plast;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (state inside {S_RESP, S_RDOUT});
  assign posx = XW'(position);
  assign cntx = XW'(count);
  assign add_ok = (position != '0) && (posx <= cntx + XW'(1));
  assign rng_ok = (position != '0) && (posx <= cntx);
  assign full = (cntx >= XW'(CAPACITY));
  assign pos_idx = AW'(posx - XW'(1));
  assign nsel = (cntx > XW'(ple_pkg::MAX_RESULTS)) ? XW'(ple_pkg::MAX_RESULTS) : cntx;
  assign plast = ((XW'(pidx) + XW'(1)) == XW'(pcount)) || !is_print;

  always_comb begin
    resp_status_next = ple_pkg::ST_OK;
    case (kind)
      ple_pkg::KIND_ADD: begin
        if (!add_ok) begin
          resp_status_next = ple_pkg::ST_BADPOS;
        end else if (full) begin
          resp_status_next = ple_pkg::ST_FULL;
        end
      end
      ple_pkg::KIND_DELETE, ple_pkg::KIND_GET: begin
        if (!rng_ok) begin
          resp_status_next = ple_pkg::ST_BADPOS;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re = 1'b0;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && kind == ple_pkg::KIND_GET && rng_ok) begin
          mem_re = 1'b1;
          mem_raddr = pos_idx;
        end else if (accept && kind == ple_pkg::KIND_PRINT && count != '0) begin
          mem_re = 1'b1;
          mem_raddr = '0;
        end
      end
      S_SHUP, S_SHDN: begin
        mem_we = wpend;
        mem_waddr = wptr;
        mem_wdata = rdata;
        mem_re = rd_active;
        mem_raddr = rptr;
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_waddr = p_idx;
        mem_wdata = p_item;
      end
      S_RDOUT: begin
        if (out_free && !plast) begin
          mem_re = 1'b1;
          mem_raddr = pidx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  ple_ram #(
    .DEPTH(CAPACITY),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      rd_active <= 1'b0;
      wpend <= 1'b0;
      is_print <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            p_idx <= pos_idx;
            p_item <= item;
            resp_status <= resp_status_next;
            is_print <= (kind == ple_pkg::KIND_PRINT);
            wpend <= 1'b0;
            case (kind)
              ple_pkg::KIND_ADD: begin
                if (!add_ok || full) begin
                  state <= S_RESP;
                end else if (posx == cntx + XW'(1)) begin
                  state <= S_PUT;
                end else begin
                  rptr <= AW'(cntx - XW'(1));
                  limit <= pos_idx;
                  rd_active <= 1'b1;
                  state <= S_SHUP;
                end
              end
              ple_pkg::KIND_DELETE: begin
                if (!rng_ok) begin
                  state <= S_RESP;
                end else if (posx == cntx) begin
                  count <= count - CW'(1);
                  state <= S_RESP;
                end else begin
                  rptr <= AW'(posx);
                  limit <= AW'(cntx - XW'(1));
                  rd_active <= 1'b1;
                  state <= S_SHDN;
                end
              end
              ple_pkg::KIND_GET: begin
                if (!rng_ok) begin
                  state <= S_RESP;
                end else begin
                  state <= S_RDOUT;
                end
              end
              default: begin
                if (count == '0) begin
                  state <= S_RESP;
                end else begin
                  pidx <= '0;
                  pcount <= CW'(nsel);
                  state <= S_RDOUT;
                end
              end
            endcase
          end
        end
        S_SHUP, S_SHDN: begin
          if (rd_active) begin
            wpend <= 1'b1;
            wptr <= (state == S_SHUP) ? rptr + AW'(1) : rptr - AW'(1);
            if (rptr == limit) begin
              rd_active <= 1'b0;
            end else begin
              rptr <= (state == S_SHUP) ? rptr - AW'(1) : rptr + AW'(1);
            end
          end else begin
            wpend <= 1'b0;
            if (state == S_SHUP) begin
              state <= S_PUT;
            end else begin
              count <= count - CW'(1);
              state <= S_RESP;
            end
          end
        end
        S_PUT: begin
          count <= count + CW'(1);
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            status <= resp_status;
            data <= '0;
            data_valid <= 1'b0;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RDOUT: begin
          if (out_free) begin
            status <= ple_pkg::ST_OK;
            data <= rdata;
            data_valid <= 1'b1;
            last <= plast;
            if (plast) begin
              state <= S_IDLE;
            end else begin
              pidx <= pidx + AW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ple_ram.sv
// Item store: one write port and one registered read port.
module ple_ram #(
  parameter int DEPTH = ple_pkg::CAPACITY_DEFAULT,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ple_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [ple_pkg::DATA_W-1:0] rdata
);

  logic [ple_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
